[hdl/dkf_pkg.sv]
package dkf_pkg;

  // field widths
  localparam int CH_W       = 4;
  localparam int DATA_W     = 32;
  localparam int A_W        = 18;
  localparam int B_W        = 17;
  localparam int H_W        = 19;
  localparam int NOISE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CHANNELS_DEF = 9;

  // internal value widths
  localparam int T_W     = 34;            // rnd(a*p)
  localparam int AX_W    = 34;            // rnd(a*x)
  localparam int HP_W    = 35;            // rnd(h*pp)
  localparam int S_W     = 39;            // rnd(h*hp) + r
  localparam int K_W     = 32;            // gain
  localparam int F_W     = 17;            // 1 - k*h, clamped
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = PROD_W - FRAC_W;
  localparam int SUM_W   = 55;

  // divider: quotient bits retired per cycle
  localparam int DIV_STEP = 2;

  localparam logic [DATA_W-1:0] ONE_Q16 = DATA_W'(65536);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
  localparam logic signed [SUM_W-1:0] U32_MAX = SUM_W'(64'sh0000_0000_FFFF_FFFF);
  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATE_GAIN    = 3'd0,
    CFG_CONTROL_GAIN  = 3'd1,
    CFG_PROCESS_NOISE = 3'd2,
    CFG_MEASURE_GAIN  = 3'd3,
    CFG_MEASURE_NOISE = 3'd4
  } cfg_idx_t;

  localparam logic [A_W-1:0]     STATE_GAIN_RST    = A_W'(65536);
  localparam logic [B_W-1:0]     CONTROL_GAIN_RST  = B_W'(131);
  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = NOISE_W'(85197);
  localparam logic [H_W-1:0]     MEASURE_GAIN_RST  = H_W'(78643);
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = NOISE_W'(6553600);

  typedef struct packed {
    logic [A_W-1:0]     a;
    logic [B_W-1:0]     b;
    logic [NOISE_W-1:0] q;
    logic [H_W-1:0]     h;
    logic [NOISE_W-1:0] r;
  } coef_t;

  // microcode fields
  typedef enum logic [3:0] {
    MUL_NONE, MUL_AP, MUL_AX, MUL_AT, MUL_BU, MUL_HPP,
    MUL_HXP, MUL_HHP, MUL_KE, MUL_KH, MUL_FPP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ADD_ZERO, ADD_Q, ADD_R, ADD_AX, ADD_Y, ADD_XP, ADD_ONE
  } add_sel_t;

  typedef enum logic [1:0] {
    SAT_NONE, SAT_U32, SAT_S32, SAT_CLAMP0
  } sat_sel_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_T, DST_PP, DST_AX, DST_XP, DST_HP,
    DST_S, DST_E, DST_XN, DST_F, DST_PN
  } dst_t;

  typedef enum logic [2:0] {
    COND_NONE, COND_ALWAYS, COND_NO_INPUT, COND_BAD_CH, COND_DIV_BUSY, COND_OUT_FULL
  } cond_t;

  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_READ     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_AP   = 5'd2;
  localparam logic [STEP_W-1:0] STEP_T        = 5'd3;
  localparam logic [STEP_W-1:0] STEP_AX       = 5'd4;
  localparam logic [STEP_W-1:0] STEP_PP       = 5'd5;
  localparam logic [STEP_W-1:0] STEP_XP       = 5'd6;
  localparam logic [STEP_W-1:0] STEP_HP       = 5'd7;
  localparam logic [STEP_W-1:0] STEP_E        = 5'd8;
  localparam logic [STEP_W-1:0] STEP_S        = 5'd9;
  localparam logic [STEP_W-1:0] STEP_DIV_GO   = 5'd10;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT = 5'd11;
  localparam logic [STEP_W-1:0] STEP_MUL_KE   = 5'd12;
  localparam logic [STEP_W-1:0] STEP_XN       = 5'd13;
  localparam logic [STEP_W-1:0] STEP_F        = 5'd14;
  localparam logic [STEP_W-1:0] STEP_MUL_FPP  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_PN       = 5'd16;
  localparam logic [STEP_W-1:0] STEP_OUT      = 5'd17;

  typedef struct packed {
    logic              in_ready;
    logic              rd;
    mul_sel_t          mul;
    add_sel_t          add;
    logic              neg;
    sat_sel_t          sat;
    dst_t              dst;
    logic              div_start;
    logic              done;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic bad_ch;
    logic div_busy;
    logic out_full;
  } status_t;

  localparam ctl_t CTL_NOP = '{
    in_ready:  1'b0,
    rd:        1'b0,
    mul:       MUL_NONE,
    add:       ADD_ZERO,
    neg:       1'b0,
    sat:       SAT_NONE,
    dst:       DST_NONE,
    div_start: 1'b0,
    done:      1'b0,
    cond:      COND_NONE,
    target:    STEP_IDLE
  };

  // control store; the post stage of each step works on the product of the step before
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t c;
    c = CTL_NOP;
    case (step)
      STEP_IDLE: begin
        c.in_ready = 1'b1;
        c.cond     = COND_NO_INPUT;
        c.target   = STEP_IDLE;
      end
      STEP_READ: begin
        c.rd     = 1'b1;
        c.cond   = COND_BAD_CH;
        c.target = STEP_OUT;
      end
      STEP_MUL_AP: begin
        c.mul = MUL_AP;
      end
      STEP_T: begin
        c.mul = MUL_AX;
        c.dst = DST_T;
      end
      STEP_AX: begin
        c.mul = MUL_AT;
        c.dst = DST_AX;
      end
      STEP_PP: begin
        c.mul = MUL_BU;
        c.add = ADD_Q;
        c.sat = SAT_U32;
        c.dst = DST_PP;
      end
      STEP_XP: begin
        c.mul = MUL_HPP;
        c.add = ADD_AX;
        c.sat = SAT_S32;
        c.dst = DST_XP;
      end
      STEP_HP: begin
        c.mul = MUL_HXP;
        c.dst = DST_HP;
      end
      STEP_E: begin
        c.mul = MUL_HHP;
        c.add = ADD_Y;
        c.neg = 1'b1;
        c.sat = SAT_S32;
        c.dst = DST_E;
      end
      STEP_S: begin
        c.add = ADD_R;
        c.dst = DST_S;
      end
      STEP_DIV_GO: begin
        c.div_start = 1'b1;
      end
      STEP_DIV_WAIT: begin
        c.cond   = COND_DIV_BUSY;
        c.target = STEP_DIV_WAIT;
      end
      STEP_MUL_KE: begin
        c.mul = MUL_KE;
      end
      STEP_XN: begin
        c.mul = MUL_KH;
        c.add = ADD_XP;
        c.sat = SAT_S32;
        c.dst = DST_XN;
      end
      STEP_F: begin
        c.add = ADD_ONE;
        c.neg = 1'b1;
        c.sat = SAT_CLAMP0;
        c.dst = DST_F;
      end
      STEP_MUL_FPP: begin
        c.mul = MUL_FPP;
      end
      STEP_PN: begin
        c.sat = SAT_U32;
        c.dst = DST_PN;
      end
      STEP_OUT: begin
        c.done   = 1'b1;
        c.cond   = COND_OUT_FULL;
        c.target = STEP_OUT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

[hdl/diagonal_kalman_filter.sv]
// channel   dir   signals                      content
// -------   ---   -------------------------    ------------------------------------------
// s_*       in    tvalid tready tdata tuser    one item: channel, measurement y, control u
// m_*       out   tvalid tready tdata tuser    one result: channel, estimate x, variance p
// cfg_*     in    wen index wdata              coefficient writes a, b, q, h, r
//
// one word is in flight at a time. a saturating gain or a zero denominator skips the
// divider wait, and a channel beyond the store goes from read straight to the output
// step. the radix-4 gain divider adds wait steps; the other steps are idle, read, one
// shared multiply or round/add step each, and the output step
// reset (rst, synchronous) returns the sequencer to idle, keeps the input closed and
// marks every channel as unwritten, so it reads estimate 0 and variance 1.0
// a result waits in the output register while the next word is already taken in;
// the sequencer only holds at its last step if that register is still full
module diagonal_kalman_filter #(
  parameter int CHANNELS = dkf_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [2*dkf_pkg::DATA_W-1:0]      s_tdata,   // measurement, control
  input  logic [dkf_pkg::CH_W-1:0]          s_tuser,   // channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*dkf_pkg::DATA_W-1:0]      m_tdata,   // estimate, variance
  output logic [dkf_pkg::CH_W-1:0]          m_tuser,   // channel_out
  input  logic                              cfg_wen,
  input  logic [dkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dkf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DW = dkf_pkg::DATA_W;

  dkf_pkg::coef_t   coef;
  dkf_pkg::ctl_t    ctl;
  dkf_pkg::status_t st;
  logic             commit;
  logic             in_fire;
  logic [dkf_pkg::CH_W-1:0] dp_ch;
  logic             dp_bad_ch;
  logic             dp_div_busy;
  logic signed [DW-1:0] dp_xn;
  logic [DW-1:0]    dp_pn;

  // coefficient registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a <= dkf_pkg::STATE_GAIN_RST;
      coef.b <= dkf_pkg::CONTROL_GAIN_RST;
      coef.q <= dkf_pkg::PROCESS_NOISE_RST;
      coef.h <= dkf_pkg::MEASURE_GAIN_RST;
      coef.r <= dkf_pkg::MEASURE_NOISE_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dkf_pkg::CFG_STATE_GAIN:    coef.a <= cfg_wdata[dkf_pkg::A_W-1:0];
        dkf_pkg::CFG_CONTROL_GAIN:  coef.b <= cfg_wdata[dkf_pkg::B_W-1:0];
        dkf_pkg::CFG_PROCESS_NOISE: coef.q <= cfg_wdata[dkf_pkg::NOISE_W-1:0];
        dkf_pkg::CFG_MEASURE_GAIN:  coef.h <= cfg_wdata[dkf_pkg::H_W-1:0];
        dkf_pkg::CFG_MEASURE_NOISE: coef.r <= cfg_wdata[dkf_pkg::NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  // input side is open only at the idle step, and never during reset
  assign s_tready = ctl.in_ready && !rst;
  assign in_fire  = s_tvalid && s_tready;

  assign st.in_valid = s_tvalid;
  assign st.bad_ch   = dp_bad_ch;
  assign st.div_busy = dp_div_busy;
  assign st.out_full = m_tvalid && !m_tready;

  dkf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .st     (st),
    .ctl    (ctl),
    .commit (commit)
  );

  dkf_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .commit   (commit),
    .in_fire  (in_fire),
    .in_ch    (s_tuser),
    .in_y     (s_tdata[DW-1:0]),
    .in_u     (s_tdata[2*DW-1:DW]),
    .coef     (coef),
    .ch       (dp_ch),
    .bad_ch   (dp_bad_ch),
    .div_busy (dp_div_busy),
    .xn       (dp_xn),
    .pn       (dp_pn)
  );

  // output register; an out-of-range channel reports zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tuser <= dp_ch;
      m_tdata <= dp_bad_ch ? '0 : {dp_pn, dp_xn};
    end
  end

  // one word at a time: the input closes right after a word is taken
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in progress");

  // a finished word always reaches the output register
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("finished word not presented on the output");

  // channels beyond the store report zero estimate and variance
  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (32'(m_tuser) >= 32'(CHANNELS))) |-> (m_tdata == '0))
    else $error("out-of-range channel returned nonzero data");

endmodule

[hdl/dkf_ram.sv]
module dkf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = dkf_pkg::CHANNELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/dkf_div.sv]
// radix-4 restoring divider: quo = floor(num * 2^16 / den), saturated to 32 bits
module dkf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dkf_pkg::HP_W-1:0]  num,
  input  logic [dkf_pkg::S_W-1:0]   den,
  output logic                      busy,
  output logic [dkf_pkg::K_W-1:0]   quo
);

  localparam int REM_W = dkf_pkg::S_W + 1;
  localparam int ITERS = dkf_pkg::K_W / dkf_pkg::DIV_STEP;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int LO_W  = dkf_pkg::K_W;
  localparam int CMP_W = dkf_pkg::S_W + dkf_pkg::FRAC_W;

  logic [REM_W-1:0]          rem;
  logic [LO_W-1:0]           nlo;
  logic [dkf_pkg::S_W-1:0]   den_q;
  logic [CNT_W-1:0]          cnt;
  logic [REM_W-1:0]          rem_next;
  logic [LO_W-1:0]           nlo_next;
  logic [dkf_pkg::K_W-1:0]   quo_next;
  logic                      overflow;

  // quotient would need more than 32 bits
  assign overflow = CMP_W'(num) >= {den, dkf_pkg::FRAC_W'(0)};

  always_comb begin
    rem_next = rem;
    nlo_next = nlo;
    quo_next = quo;
    for (int i = 0; i < dkf_pkg::DIV_STEP; i++) begin
      rem_next = {rem_next[REM_W-2:0], nlo_next[LO_W-1]};
      nlo_next = {nlo_next[LO_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den_q}) begin
        rem_next = rem_next - {1'b0, den_q};
        quo_next = {quo_next[dkf_pkg::K_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[dkf_pkg::K_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      if (den == '0) begin
        busy <= 1'b0;
        quo  <= '0;
      end else if (overflow) begin
        busy <= 1'b0;
        quo  <= '1;
      end else begin
        busy  <= 1'b1;
        quo   <= '0;
        rem   <= REM_W'(num[dkf_pkg::HP_W-1:dkf_pkg::FRAC_W]);
        nlo   <= {num[dkf_pkg::FRAC_W-1:0], (LO_W - dkf_pkg::FRAC_W)'(0)};
        den_q <= den;
        cnt   <= CNT_W'(ITERS - 1);
      end
    end else if (busy) begin
      rem <= rem_next;
      nlo <= nlo_next;
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hdl/dkf_seq.sv]
// step counter over the control store
module dkf_seq (
  input  logic             clk,
  input  logic             rst,
  input  dkf_pkg::status_t st,
  output dkf_pkg::ctl_t    ctl,
  output logic             commit
);

  logic [dkf_pkg::STEP_W-1:0] pc;
  logic [dkf_pkg::STEP_W-1:0] pc_next;
  logic                       jump;

  always_comb begin
    ctl = dkf_pkg::ucode(pc);
  end

  always_comb begin
    case (ctl.cond)
      dkf_pkg::COND_NONE:     jump = 1'b0;
      dkf_pkg::COND_ALWAYS:   jump = 1'b1;
      dkf_pkg::COND_NO_INPUT: jump = !st.in_valid;
      dkf_pkg::COND_BAD_CH:   jump = st.bad_ch;
      dkf_pkg::COND_DIV_BUSY: jump = st.div_busy;
      dkf_pkg::COND_OUT_FULL: jump = st.out_full;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_next = ctl.target;
    end else if (ctl.done) begin
      pc_next = dkf_pkg::STEP_IDLE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  assign commit = ctl.done && !jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= dkf_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[hdl/dkf_datapath.sv]
// shared multiplier, round/add/saturate stage, working registers, channel store
module dkf_datapath #(
  parameter int CHANNELS = dkf_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  dkf_pkg::ctl_t                      ctl,
  input  logic                               commit,
  input  logic                               in_fire,
  input  logic [dkf_pkg::CH_W-1:0]           in_ch,
  input  logic signed [dkf_pkg::DATA_W-1:0]  in_y,
  input  logic signed [dkf_pkg::DATA_W-1:0]  in_u,
  input  dkf_pkg::coef_t                     coef,
  output logic [dkf_pkg::CH_W-1:0]           ch,
  output logic                               bad_ch,
  output logic                               div_busy,
  output logic signed [dkf_pkg::DATA_W-1:0]  xn,
  output logic [dkf_pkg::DATA_W-1:0]         pn
);

  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW  = dkf_pkg::DATA_W;
  localparam int RAM_W = 2 * DW;

  logic signed [DW-1:0]               y;
  logic signed [DW-1:0]               u;
  logic [AW-1:0]                      addr;
  logic [CHANNELS-1:0]                vld;
  logic                               vld_q;
  logic [RAM_W-1:0]                   rd_data;
  logic signed [DW-1:0]               x_old;
  logic [DW-1:0]                      p_old;

  logic [dkf_pkg::T_W-1:0]            t;
  logic [DW-1:0]                      pp;
  logic signed [dkf_pkg::AX_W-1:0]    ax;
  logic signed [DW-1:0]               xp;
  logic [dkf_pkg::HP_W-1:0]           hp;
  logic [dkf_pkg::S_W-1:0]            s;
  logic signed [DW-1:0]               e;
  logic [dkf_pkg::F_W-1:0]            f;
  logic [dkf_pkg::K_W-1:0]            k;

  logic signed [dkf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dkf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dkf_pkg::PROD_W-1:0]  prod;
  logic signed [dkf_pkg::PROD_W-1:0]  rsum;
  logic signed [dkf_pkg::RND_W-1:0]   rnd;
  logic signed [dkf_pkg::SUM_W-1:0]   term;
  logic signed [dkf_pkg::SUM_W-1:0]   addend;
  logic signed [dkf_pkg::SUM_W-1:0]   sum;
  logic signed [dkf_pkg::SUM_W-1:0]   res;

  // input word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch <= in_ch;
      y  <= in_y;
      u  <= in_u;
    end
  end

  assign bad_ch = 32'(ch) >= 32'(CHANNELS);
  assign addr   = AW'(ch);

  // channel store: estimate low, variance high; unwritten entries read as reset values
  dkf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_state (
    .clk   (clk),
    .we    (commit && !bad_ch),
    .waddr (addr),
    .wdata ({pn, xn}),
    .re    (ctl.rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (commit && !bad_ch) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      vld_q <= vld[addr];
    end
  end

  assign x_old = vld_q ? rd_data[DW-1:0] : '0;
  assign p_old = vld_q ? rd_data[RAM_W-1:DW] : dkf_pkg::ONE_Q16;

  // multiplier operands
  always_comb begin
    case (ctl.mul)
      dkf_pkg::MUL_AP: begin
        mul_a = {4'b0, p_old};
        mul_b = {15'b0, coef.a};
      end
      dkf_pkg::MUL_AX: begin
        mul_a = {{4{x_old[DW-1]}}, x_old};
        mul_b = {15'b0, coef.a};
      end
      dkf_pkg::MUL_AT: begin
        mul_a = {2'b0, t};
        mul_b = {15'b0, coef.a};
      end
      dkf_pkg::MUL_BU: begin
        mul_a = {{4{u[DW-1]}}, u};
        mul_b = {16'b0, coef.b};
      end
      dkf_pkg::MUL_HPP: begin
        mul_a = {4'b0, pp};
        mul_b = {14'b0, coef.h};
      end
      dkf_pkg::MUL_HXP: begin
        mul_a = {{4{xp[DW-1]}}, xp};
        mul_b = {14'b0, coef.h};
      end
      dkf_pkg::MUL_HHP: begin
        mul_a = {1'b0, hp};
        mul_b = {14'b0, coef.h};
      end
      dkf_pkg::MUL_KE: begin
        mul_a = {4'b0, k};
        mul_b = {e[DW-1], e};
      end
      dkf_pkg::MUL_KH: begin
        mul_a = {4'b0, k};
        mul_b = {14'b0, coef.h};
      end
      dkf_pkg::MUL_FPP: begin
        mul_a = {4'b0, pp};
        mul_b = {16'b0, f};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // round half up, then add or subtract from the selected term
  assign rsum = prod + dkf_pkg::RND_HALF;
  assign rnd  = rsum[dkf_pkg::PROD_W-1:dkf_pkg::FRAC_W];
  assign term = ctl.neg ? -dkf_pkg::SUM_W'(rnd) : dkf_pkg::SUM_W'(rnd);

  always_comb begin
    case (ctl.add)
      dkf_pkg::ADD_ZERO: addend = '0;
      dkf_pkg::ADD_Q:    addend = dkf_pkg::SUM_W'(coef.q);
      dkf_pkg::ADD_R:    addend = dkf_pkg::SUM_W'(coef.r);
      dkf_pkg::ADD_AX:   addend = dkf_pkg::SUM_W'(ax);
      dkf_pkg::ADD_Y:    addend = dkf_pkg::SUM_W'(y);
      dkf_pkg::ADD_XP:   addend = dkf_pkg::SUM_W'(xp);
      dkf_pkg::ADD_ONE:  addend = dkf_pkg::SUM_W'(dkf_pkg::ONE_Q16);
      default:           addend = '0;
    endcase
  end

  assign sum = addend + term;

  always_comb begin
    case (ctl.sat)
      dkf_pkg::SAT_U32: begin
        if (sum > dkf_pkg::U32_MAX) begin
          res = dkf_pkg::U32_MAX;
        end else if (sum < 0) begin
          res = '0;
        end else begin
          res = sum;
        end
      end
      dkf_pkg::SAT_S32: begin
        if (sum > dkf_pkg::S32_MAX) begin
          res = dkf_pkg::S32_MAX;
        end else if (sum < dkf_pkg::S32_MIN) begin
          res = dkf_pkg::S32_MIN;
        end else begin
          res = sum;
        end
      end
      dkf_pkg::SAT_CLAMP0: res = (sum < 0) ? '0 : sum;
      default:             res = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctl.dst)
      dkf_pkg::DST_T:  t  <= res[dkf_pkg::T_W-1:0];
      dkf_pkg::DST_PP: pp <= res[DW-1:0];
      dkf_pkg::DST_AX: ax <= res[dkf_pkg::AX_W-1:0];
      dkf_pkg::DST_XP: xp <= res[DW-1:0];
      dkf_pkg::DST_HP: hp <= res[dkf_pkg::HP_W-1:0];
      dkf_pkg::DST_S:  s  <= res[dkf_pkg::S_W-1:0];
      dkf_pkg::DST_E:  e  <= res[DW-1:0];
      dkf_pkg::DST_XN: xn <= res[DW-1:0];
      dkf_pkg::DST_F:  f  <= res[dkf_pkg::F_W-1:0];
      dkf_pkg::DST_PN: pn <= res[DW-1:0];
      default: ;
    endcase
  end

  // gain k = hp * 2^16 / s
  dkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (hp),
    .den   (s),
    .busy  (div_busy),
    .quo   (k)
  );

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = dkf_pkg::CHANNELS_DEF;
  localparam int CH_W     = dkf_pkg::CH_W;
  localparam int DATA_W   = dkf_pkg::DATA_W;
  localparam int IDX_W    = dkf_pkg::CFG_IDX_W;
  localparam int WDATA_W  = dkf_pkg::CFG_DATA_W;

  // wide signed scratch type, holds every exact product of the filter step
  typedef logic signed [95:0] wide_t;

  // one result word as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] est;
    logic [DATA_W-1:0] vari;
  } kf_word_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [2*DATA_W-1:0]     s_tdata = '0;   // measurement, control
  logic [CH_W-1:0]         s_tuser = '0;   // channel
  logic                    m_tvalid;
  logic                    m_tready = 1'b1;
  logic [2*DATA_W-1:0]     m_tdata;        // estimate, variance
  logic [CH_W-1:0]         m_tuser;        // channel_out
  logic                    cfg_wen = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [WDATA_W-1:0]      cfg_wdata = '0;

  // predictor state: coefficients and per-channel filter memory
  dkf_pkg::coef_t           coef_model;
  logic signed [DATA_W-1:0] est_mem [CHANNELS];
  logic [DATA_W-1:0]        var_mem [CHANNELS];

  kf_word_t pending_results[$];
  int       mismatches = 0;

  // idling controls, changed per test
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;
  int burst_left = 0;
  int rx_left = 0;
  bit rx_busy = 1'b0;

  diagonal_kalman_filter #(.CHANNELS(CHANNELS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // filter arithmetic
  // ---------------------------------------------------------------------------

  // round half up to q16.16, floor after adding half an lsb
  function automatic wide_t rnd(input wide_t v);
    return (v + wide_t'(32768)) >>> dkf_pkg::FRAC_W;
  endfunction

  function automatic wide_t sat_s(input wide_t v);
    if (v > dkf_pkg::S32_MAX) return dkf_pkg::S32_MAX;
    if (v < dkf_pkg::S32_MIN) return dkf_pkg::S32_MIN;
    return v;
  endfunction

  function automatic wide_t sat_u(input wide_t v);
    return (v > dkf_pkg::U32_MAX) ? wide_t'(dkf_pkg::U32_MAX) : v;
  endfunction

  // one predict/correct step on a channel; updates the filter memory
  function automatic kf_word_t filter_step(input logic [CH_W-1:0] ch,
                                           input logic signed [DATA_W-1:0] y,
                                           input logic signed [DATA_W-1:0] u);
    kf_word_t res;
    wide_t a, b, q, h, r, x, p, t, pp, xp, hp, s, k, e, xn, kh, f, pn;
    res.ch   = ch;
    res.est  = '0;
    res.vari = '0;
    // channel beyond the filter bank: zeros out, nothing stored
    if (ch >= CHANNELS) return res;
    a = coef_model.a;
    b = coef_model.b;
    q = coef_model.q;
    h = coef_model.h;
    r = coef_model.r;
    x = est_mem[ch];
    p = var_mem[ch];
    // predict
    t  = rnd(a * p);
    pp = sat_u(rnd(a * t) + q);
    xp = sat_s(rnd(a * x) + rnd(b * u));
    // gain; a zero denominator gives no correction
    hp = rnd(h * pp);
    s  = rnd(h * hp) + r;
    k  = (s == 0) ? wide_t'(0) : sat_u((hp <<< dkf_pkg::FRAC_W) / s);
    // correct
    e  = sat_s(y - rnd(h * xp));
    xn = sat_s(xp + rnd(k * e));
    kh = rnd(k * h);
    f  = (kh >= dkf_pkg::ONE_Q16) ? wide_t'(0) : wide_t'(dkf_pkg::ONE_Q16) - kh;
    pn = sat_u(rnd(f * pp));
    est_mem[ch] = xn[DATA_W-1:0];
    var_mem[ch] = pn[DATA_W-1:0];
    res.est  = xn[DATA_W-1:0];
    res.vari = pn[DATA_W-1:0];
    return res;
  endfunction

  function automatic void apply_coef(input logic [IDX_W-1:0] idx,
                                     input logic [WDATA_W-1:0] val);
    case (idx)
      dkf_pkg::CFG_STATE_GAIN:    coef_model.a = val[dkf_pkg::A_W-1:0];
      dkf_pkg::CFG_CONTROL_GAIN:  coef_model.b = val[dkf_pkg::B_W-1:0];
      dkf_pkg::CFG_PROCESS_NOISE: coef_model.q = val[dkf_pkg::NOISE_W-1:0];
      dkf_pkg::CFG_MEASURE_GAIN:  coef_model.h = val[dkf_pkg::H_W-1:0];
      dkf_pkg::CFG_MEASURE_NOISE: coef_model.r = val[dkf_pkg::NOISE_W-1:0];
      default: ;  // unmapped index, write dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one register write; wen stays high so back-to-back writes need no toggle
  task automatic write_coef(input logic [IDX_W-1:0] idx,
                            input logic [WDATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_coef(idx, val);
  endtask

  task automatic set_coefs(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] q, input logic [31:0] h,
                           input logic [31:0] r);
    write_coef(dkf_pkg::CFG_STATE_GAIN, a);
    write_coef(dkf_pkg::CFG_CONTROL_GAIN, b);
    write_coef(dkf_pkg::CFG_PROCESS_NOISE, q);
    write_coef(dkf_pkg::CFG_MEASURE_GAIN, h);
    write_coef(dkf_pkg::CFG_MEASURE_NOISE, r);
    cfg_wen <= 1'b0;
  endtask

  // send one word; the sender runs in bursts, with gaps in between when gaps_on is set
  task automatic send_word(input logic [CH_W-1:0] ch, input logic [31:0] y,
                           input logic [31:0] u);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (gaps_on) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= ch;
    s_tdata  <= {u, y};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(filter_step(ch, y, u));
  endtask

  // wait for every outstanding result, then let the sequencer settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: always ready, or with stalls_on, alternating ready and stall runs of random length
  always @(posedge clk) begin
    if (!stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_busy = !rx_busy;
        rx_left = rx_busy ? $urandom_range(1, 40) : $urandom_range(1, 20);
      end
      rx_left--;
      m_tready <= !rx_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    kf_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: ch %0d est %h var %h",
                   m_tuser, m_tdata[31:0], m_tdata[63:32]);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.ch || m_tdata[31:0] !== want.est ||
            m_tdata[63:32] !== want.vari) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ch %0d est %h var %h, got ch %0d est %h var %h",
                     want.ch, want.est, want.vari,
                     m_tuser, m_tdata[31:0], m_tdata[63:32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // measurement or control value: small, moderate, full range or extreme
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: return v;
      1: return {{10{v[31]}}, v[21:0]};
      2: return {{6{v[31]}}, v[25:0]};
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(0, 9) == 0) return CH_W'($urandom_range(CHANNELS, 2**CH_W - 1));
    return CH_W'($urandom_range(0, CHANNELS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset coefficients and memory on every channel
  task automatic test_defaults();
    for (int c = 0; c < CHANNELS; c++)
      send_word(CH_W'(c), 32'h0001_0000 * c, 32'h0000_8000);
    drain_results();
  endtask

  // field extremes on two channels
  task automatic test_field_extremes();
    send_word(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(4'd0, 32'h8000_0000, 32'h8000_0000);
    send_word(4'd8, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(4'd8, 32'h0000_0000, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // out-of-range channel: zero result, no state change
  task automatic test_bad_channel();
    send_word(4'd9, 32'h1234_5678, 32'h8765_4321);
    send_word(4'd15, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
  endtask

  // h and r zero make the gain denominator zero
  task automatic test_zero_denominator();
    set_coefs(32'd65536, 32'd131, 32'd85197, 32'd0, 32'd0);
    send_word(4'd1, 32'h0010_0000, 32'h0100_0000);
    send_word(4'd1, 32'hFFF0_0000, 32'hFF00_0000);
    drain_results();
  endtask

  // tiny h with r zero and huge q: gain saturates and 1 - k*h clamps at zero
  task automatic test_gain_saturation();
    set_coefs(32'd65536, 32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_word(4'd2, 32'h0100_0000, 32'h0000_1000);
    send_word(4'd2, 32'h8000_0000, 32'h7FFF_FFFF);
    drain_results();
  endtask

  // coefficient extremes, including writes wider than the register
  task automatic test_coef_extremes();
    set_coefs(32'd131072, 32'd65536, 32'hFFFF_FFFF, 32'd262144, 32'hFFFF_FFFF);
    send_word(4'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain_results();
    set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_word(4'd4, 32'h8000_0000, 32'h8000_0000);
    drain_results();
    set_coefs(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    send_word(4'd5, 32'h0001_0000, 32'h0001_0000);
    drain_results();
  endtask

  // writes to unmapped indexes must leave the coefficients alone
  task automatic test_unmapped_index();
    set_coefs(32'd65536, 32'd131, 32'd85197, 32'd78643, 32'd6553600);
    @(posedge clk);
    for (int i = int'(dkf_pkg::CFG_MEASURE_NOISE) + 1; i < 2**IDX_W; i++)
      write_coef(IDX_W'(i), $urandom);
    cfg_wen <= 1'b0;
    send_word(4'd6, 32'h0020_0000, 32'hFFE0_0000);
    send_word(4'd7, 32'hFFC0_0000, 32'h0040_0000);
    drain_results();
  endtask

  // random words over several coefficient settings and idling mixes
  task automatic test_random();
    logic [31:0] a, b, q, h, r;
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on   = ph[0];
      stalls_on = ph[1];
      case ($urandom_range(0, 4))
        0: a = 32'd0;
        1: a = 32'd65536;
        2: a = 32'd131072;
        3: a = $urandom_range(60000, 70000);
        default: a = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: b = 32'd0;
        1: b = 32'd65536;
        2: b = 32'd131;
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: q = 32'd0;
        1: q = 32'hFFFF_FFFF;
        2: q = 32'd85197;
        default: q = $urandom_range(0, 2**20);
      endcase
      case ($urandom_range(0, 4))
        0: h = 32'd0;
        1: h = 32'd262144;
        2: h = 32'd78643;
        3: h = $urandom_range(0, 2**dkf_pkg::H_W - 1);
        default: h = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: r = 32'd0;
        1: r = 32'hFFFF_FFFF;
        2: r = 32'd6553600;
        default: r = $urandom_range(0, 2**24);
      endcase
      // first phase keeps the usual filter settings
      if (ph == 0) set_coefs(32'd65536, 32'd131, 32'd85197, 32'd78643, 32'd6553600);
      else set_coefs(a, b, q, h, r);
      repeat (250) send_word(pick_channel(), pick_value(), pick_value());
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    coef_model.a = dkf_pkg::STATE_GAIN_RST;
    coef_model.b = dkf_pkg::CONTROL_GAIN_RST;
    coef_model.q = dkf_pkg::PROCESS_NOISE_RST;
    coef_model.h = dkf_pkg::MEASURE_GAIN_RST;
    coef_model.r = dkf_pkg::MEASURE_NOISE_RST;
    for (int c = 0; c < CHANNELS; c++) begin
      est_mem[c] = '0;
      var_mem[c] = dkf_pkg::ONE_Q16;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_field_extremes();
    test_bad_channel();
    test_zero_denominator();
    test_gain_saturation();
    test_coef_extremes();
    test_unmapped_index();
    test_random();

    // late stray words would show up as unexpected
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
